FILE: src/i2cbm_pkg.sv
// ---------------------------------------------------------------------------
// i2cbm_pkg: shared types and constants of the i2c bit level master
// request and response payloads, configuration, command codes
// ---------------------------------------------------------------------------
package i2cbm_pkg;

   localparam int unsigned TPU_W   = 10;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned DELAY_W = 13;

   // command codes carried in the kind field
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_STOP  = 3'd1;
   localparam logic [2:0] KIND_WRITE = 3'd2;
   localparam logic [2:0] KIND_ACK   = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_US   = 1'b0;
   localparam logic CSR_ACK_POLL_LIMIT = 1'b1;

   localparam logic [TPU_W-1:0]   TICKS_PER_US_RST   = 10'd100;
   localparam logic [LIMIT_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

   typedef struct packed {
      logic                 cmd_valid;
      logic [2:0]           kind;
      logic [7:0]           write_data;
      logic                 send_ack;
      logic                 sda_in;
   } req_type;

   typedef struct packed {
      logic                 scl;
      logic                 sda_out;
      logic                 sda_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [7:0]           read_data;
      logic                 ack_failed;
   } rsp_type;

   typedef struct packed {
      logic [TPU_W-1:0]     ticks_per_us;
      logic [LIMIT_W-1:0]   ack_poll_limit;
   } cfg_type;

endpackage

FILE: src/i2cbm_seq.sv
// ---------------------------------------------------------------------------
// i2cbm_seq: bus sequencer of the i2c bit level master
// phase state machine, delay counter, shifter and pin registers
// ---------------------------------------------------------------------------
module i2cbm_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  i2cbm_pkg::req_type req,
   input  i2cbm_pkg::cfg_type cfg,
   output i2cbm_pkg::rsp_type rsp
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
      PH_ACK_A, PH_ACK_B, PH_POLL, PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW,
      PH_RX_LOW, PH_RX_HIGH, PH_AK_LOW, PH_AK_HIGH
   } phase_type;

   // delay length as log2 of the unit count
   localparam logic [1:0] UNITS_1 = 2'd0;
   localparam logic [1:0] UNITS_2 = 2'd1;
   localparam logic [1:0] UNITS_4 = 2'd2;

   phase_type                            phase_ff, phase_in;
   logic [i2cbm_pkg::DELAY_W-1:0]        delay_ff, delay_in;
   logic [3:0]                           bit_ff, bit_in;
   logic [7:0]                           shift_ff, shift_in;
   logic [i2cbm_pkg::LIMIT_W-1:0]        poll_ff, poll_in;
   logic                                 scl_ff, scl_in;
   logic                                 sda_ff, sda_in;
   logic                                 drive_ff, drive_in;
   logic                                 ack_choice_ff, ack_choice_in;
   logic                                 fail_ff, fail_in;
   logic [7:0]                           read_ff, read_in;
   logic                                 done_in;
   logic [i2cbm_pkg::TPU_W-1:0]          tpu;
   logic [i2cbm_pkg::LIMIT_W:0]          poll_next;
   logic [3:0]                           bit_next;
   logic                                 do_poll;

   function automatic logic [i2cbm_pkg::DELAY_W-1:0] unit_delay(
      input logic [i2cbm_pkg::TPU_W-1:0] t,
      input logic [1:0]                  sh
   );
      logic [i2cbm_pkg::DELAY_W-1:0] w;
      w = {{(i2cbm_pkg::DELAY_W-i2cbm_pkg::TPU_W){1'b0}}, t} << sh;
      return w - {{(i2cbm_pkg::DELAY_W-1){1'b0}}, 1'b1};
   endfunction

   assign tpu       = (cfg.ticks_per_us == '0) ? {{(i2cbm_pkg::TPU_W-1){1'b0}}, 1'b1}
                                                : cfg.ticks_per_us;
   assign poll_next = {1'b0, poll_ff} + {{i2cbm_pkg::LIMIT_W{1'b0}}, 1'b1};
   assign bit_next  = bit_ff + 4'd1;
   // ack sampling happens every tick in the poll phase and when the ack high phase ends
   assign do_poll   = (phase_ff == PH_POLL) || (phase_ff == PH_ACK_B && delay_ff == '0);

   always_comb begin
      phase_in      = phase_ff;
      delay_in      = delay_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      poll_in       = poll_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      ack_choice_in = ack_choice_ff;
      fail_in       = fail_ff;
      read_in       = read_ff;
      done_in       = 1'b0;

      priority if (phase_ff == PH_IDLE) begin
         if (req.cmd_valid) begin
            unique case (req.kind)
               i2cbm_pkg::KIND_START: begin
                  drive_in = 1'b1; sda_in = 1'b1; scl_in = 1'b1;
                  phase_in = PH_START_A; delay_in = unit_delay(tpu, UNITS_4);
               end
               i2cbm_pkg::KIND_STOP: begin
                  drive_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
                  phase_in = PH_STOP_A; delay_in = unit_delay(tpu, UNITS_4);
               end
               i2cbm_pkg::KIND_WRITE: begin
                  drive_in = 1'b1; scl_in = 1'b0;
                  sda_in   = req.write_data[7];
                  shift_in = {req.write_data[6:0], 1'b0};
                  bit_in   = 4'd0;
                  phase_in = PH_TX_SETUP; delay_in = unit_delay(tpu, UNITS_2);
               end
               i2cbm_pkg::KIND_ACK: begin
                  fail_in = 1'b0; poll_in = '0;
                  drive_in = 1'b0; sda_in = 1'b1;
                  phase_in = PH_ACK_A; delay_in = unit_delay(tpu, UNITS_1);
               end
               i2cbm_pkg::KIND_READ: begin
                  ack_choice_in = req.send_ack;
                  drive_in = 1'b0; scl_in = 1'b0;
                  shift_in = '0; bit_in = 4'd0;
                  phase_in = PH_RX_LOW; delay_in = unit_delay(tpu, UNITS_2);
               end
               default: ;
            endcase
         end
      end else if (do_poll) begin
         phase_in = PH_POLL;
         delay_in = '0;
         priority if (!req.sda_in) begin
            scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
         end else if (poll_next > {1'b0, cfg.ack_poll_limit}) begin
            // timeout: flag it and release the bus with a stop
            fail_in = 1'b1; poll_in = '0;
            drive_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
            phase_in = PH_STOP_A; delay_in = unit_delay(tpu, UNITS_4);
         end else begin
            poll_in = poll_next[i2cbm_pkg::LIMIT_W-1:0];
         end
      end else if (delay_ff != '0) begin
         delay_in = delay_ff - {{(i2cbm_pkg::DELAY_W-1){1'b0}}, 1'b1};
      end else begin
         unique case (phase_ff)
            PH_START_A: begin
               sda_in = 1'b0; phase_in = PH_START_B; delay_in = unit_delay(tpu, UNITS_4);
            end
            PH_START_B: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
            end
            PH_STOP_A: begin
               scl_in = 1'b1; sda_in = 1'b1;
               phase_in = PH_STOP_B; delay_in = unit_delay(tpu, UNITS_4);
            end
            PH_STOP_B: begin
               phase_in = PH_IDLE; done_in = 1'b1;
            end
            PH_ACK_A: begin
               scl_in = 1'b1; phase_in = PH_ACK_B; delay_in = unit_delay(tpu, UNITS_1);
            end
            PH_TX_SETUP: begin
               scl_in = 1'b1; phase_in = PH_TX_HIGH; delay_in = unit_delay(tpu, UNITS_2);
            end
            PH_TX_HIGH: begin
               scl_in = 1'b0; phase_in = PH_TX_LOW; delay_in = unit_delay(tpu, UNITS_2);
            end
            PH_TX_LOW: begin
               bit_in = bit_next;
               if (bit_next >= 4'd8) begin
                  phase_in = PH_IDLE; done_in = 1'b1;
               end else begin
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  phase_in = PH_TX_SETUP; delay_in = unit_delay(tpu, UNITS_2);
               end
            end
            PH_RX_LOW: begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], req.sda_in};
               phase_in = PH_RX_HIGH; delay_in = unit_delay(tpu, UNITS_1);
            end
            PH_RX_HIGH: begin
               bit_in = bit_next;
               scl_in = 1'b0;
               if (bit_next < 4'd8) begin
                  phase_in = PH_RX_LOW; delay_in = unit_delay(tpu, UNITS_2);
               end else begin
                  read_in  = shift_ff;
                  drive_in = 1'b1;
                  sda_in   = ~ack_choice_ff;
                  phase_in = PH_AK_LOW; delay_in = unit_delay(tpu, UNITS_2);
               end
            end
            PH_AK_LOW: begin
               scl_in = 1'b1; phase_in = PH_AK_HIGH; delay_in = unit_delay(tpu, UNITS_2);
            end
            PH_AK_HIGH: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE; delay_in = '0;
            end
         endcase
      end

      // a finished command leaves the delay counter cleared
      if (done_in) begin
         delay_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         delay_ff      <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         poll_ff       <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         ack_choice_ff <= 1'b0;
         fail_ff       <= 1'b0;
         read_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         delay_ff      <= delay_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         poll_ff       <= poll_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         drive_ff      <= drive_in;
         ack_choice_ff <= ack_choice_in;
         fail_ff       <= fail_in;
         read_ff       <= read_in;
      end
   end

   always_comb begin
      rsp.scl        = scl_in;
      rsp.sda_out    = sda_in;
      rsp.sda_drive  = drive_in;
      rsp.busy_res   = (phase_in != PH_IDLE);
      rsp.done_res   = done_in;
      rsp.read_data  = read_in;
      rsp.ack_failed = fail_in;
   end

endmodule

FILE: src/i2c_bit_level_master_unit.sv
// ---------------------------------------------------------------------------
// i2c_bit_level_master_unit: tick driven i2c master, top level
// configuration registers, request handshake and response register
// ---------------------------------------------------------------------------
//  channel   ports                          direction  payload
//  request   req_valid req_ready req_data   in         one tick: command + sda sample
//  response  rsp_valid rsp_ready rsp_data   out        pin levels and status after tick
//  config    csr_we csr_index csr_wdata     in         ticks_per_us, ack_poll_limit
//
//  one request per cycle when not stalled; response in the cycle after acceptance
//  the sequencer state and response register update in that same edge
//  a held response stalls requests only while rsp_ready is low
//  reset (synchronous) idles the sequencer, drives scl and sda high, loads defaults
// ---------------------------------------------------------------------------
module i2c_bit_level_master_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  i2cbm_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output i2cbm_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [i2cbm_pkg::TPU_W-1:0]         csr_wdata
);

   i2cbm_pkg::cfg_type cfg_ff;
   i2cbm_pkg::rsp_type rsp_next;
   i2cbm_pkg::rsp_type rsp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   // a request goes in whenever the response register is free or being emptied
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us   <= i2cbm_pkg::TICKS_PER_US_RST;
         cfg_ff.ack_poll_limit <= i2cbm_pkg::ACK_POLL_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cbm_pkg::CSR_TICKS_PER_US:   cfg_ff.ticks_per_us <= csr_wdata;
            i2cbm_pkg::CSR_ACK_POLL_LIMIT:
               cfg_ff.ack_poll_limit <= csr_wdata[i2cbm_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer advances one tick per accepted request
   i2cbm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every accepted request yields a response in the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   // a completion pulse always reports the bus as no longer busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done pulse while still busy");

   // a held response is only replaced after it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !accept)
      else $error("request accepted over a pending response");

endmodule
